/* hdl/kpft_pkg.sv */
// package with shared types and constants for the keyed pending flag table
`timescale 1ns / 1ps
package kpft_pkg;

    localparam int KPFT_TABLE_DEPTH = 64;
    localparam int KPFT_CORE_COUNT  = 64;
    localparam int KEY_W            = 64;
    localparam int CORE_W           = 6;
    localparam int MODE_W           = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_QUERY  = 3'd2,
        MODE_RAISE  = 3'd3,
        MODE_TAKE   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FRD,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic set;
        logic clr;
    } t_key_cmd;

    typedef struct packed {
        logic done;
        logic hit;
        logic free_ok;
    } t_scan_res;

endpackage

/* hdl/kpft_scan.sv */
// key store with valid bits and a serial match and free-slot scan
`timescale 1ns / 1ps
module kpft_scan import kpft_pkg::*; #(
    parameter int TABLE_DEPTH = KPFT_TABLE_DEPTH
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic [KEY_W-1:0]                            i_key,
    input  t_key_cmd                                    i_cmd,
    input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] i_wr_idx,
    output t_scan_res                                   o_res,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] o_hit_idx,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] o_free_idx
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    logic [KEY_W-1:0]       r_key_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;

    logic             r_busy;
    logic [IW-1:0]    r_idx;
    logic             r_cmp;
    logic             r_cmp_last;
    logic [IW-1:0]    r_cmp_idx;
    logic [KEY_W-1:0] r_rd_key;
    logic             r_rd_vld;
    logic             r_done;
    logic             r_hit;
    logic             r_free_ok;
    logic [IW-1:0]    r_hit_idx;
    logic [IW-1:0]    r_free_idx;
    logic             match;

    // key memory: one write port, one registered read port on the scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.set) begin
            r_key_mem[i_wr_idx] <= i_key;
        end
        r_rd_key <= r_key_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.set) begin
            r_valid[i_wr_idx] <= 1'b1;
        end else if (i_cmd.clr) begin
            r_valid[i_wr_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld  <= r_valid[r_idx];
        r_cmp_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_idx      <= '0;
            r_cmp      <= 1'b0;
            r_cmp_last <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_cmp      <= r_busy;
            r_cmp_last <= r_busy && (r_idx == LAST_IDX);
            r_done     <= r_cmp && r_cmp_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (r_idx == LAST_IDX) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign match = r_cmp && r_rd_vld && (r_rd_key == i_key) && (i_key != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (i_start) begin
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            if (match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (r_cmp && !r_rd_vld && !r_free_ok) begin
                r_free_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (match && !r_hit) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (r_cmp && !r_rd_vld && !r_free_ok) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    assign o_res.done    = r_done;
    assign o_res.hit     = r_hit;
    assign o_res.free_ok = r_free_ok;
    assign o_hit_idx     = r_hit_idx;
    assign o_free_idx    = r_free_idx;

endmodule

/* hdl/keyed_pending_flag_table.sv */
// top level of the keyed pending flag table
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+------------------------------
//  in      | i_in_valid | o_in_stall  | i_mode, i_key, i_core
//  out     | o_out_valid| i_out_stall | o_found, o_pending, o_dropped
//  config  | i_cfg_we   | -           | i_cfg_wdata (insert enable)
//
// a transaction is a serial key scan: it reads one slot per cycle from the single
// read port of the key memory
// o_in_stall is high from the accepting edge until the result is loaded
// the result register holds a result while a new transaction is accepted
// synchronous active-low reset clears valid bits and control, no clearing pass
`timescale 1ns / 1ps
module keyed_pending_flag_table import kpft_pkg::*; #(
    parameter int TABLE_DEPTH = KPFT_TABLE_DEPTH,
    parameter int CORE_COUNT  = KPFT_CORE_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [CORE_W-1:0] i_core,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_found,
    output logic              o_pending,
    output logic              o_dropped
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_state r_state, n_state;

    logic                  r_ins_en;
    logic [MODE_W-1:0]     r_mode;
    logic [KEY_W-1:0]      r_key;
    logic [CORE_W-1:0]     r_core;
    logic [CORE_COUNT-1:0] r_flag_mem [TABLE_DEPTH];
    logic [CORE_COUNT-1:0] r_flag_rd;
    logic                  r_out_valid;
    logic                  r_found, r_pending, r_dropped;

    t_scan_res             scan_res;
    logic [IW-1:0]         hit_idx, free_idx, wr_idx;
    t_key_cmd              key_cmd;
    logic                  accept, start, fire, out_free;
    logic                  flag_we;
    logic [CORE_COUNT-1:0] flag_wdata, core_mask;
    logic [IW-1:0]         flag_widx;
    logic                  core_ok;
    logic                  res_found, res_pending, res_dropped;

    kpft_scan #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_key     (r_key),
        .i_cmd     (key_cmd),
        .i_wr_idx  (wr_idx),
        .o_res     (scan_res),
        .o_hit_idx (hit_idx),
        .o_free_idx(free_idx)
    );

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        for (int j = 0; j < CORE_COUNT; j++) begin
            core_mask[j] = (r_core == CORE_W'(j));
        end
    end
    assign core_ok = |core_mask;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_res.done) n_state = ST_FRD;
            end
            ST_FRD: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        start       = (r_state == ST_IDLE) && i_in_valid;
        fire        = (r_state == ST_EXEC) && out_free;
        key_cmd     = '0;
        wr_idx      = hit_idx;
        flag_we     = 1'b0;
        flag_widx   = hit_idx;
        flag_wdata  = r_flag_rd;
        res_found   = 1'b0;
        res_pending = 1'b0;
        res_dropped = 1'b0;
        unique case (t_mode'(r_mode))
            MODE_INSERT: begin
                res_found = scan_res.hit;
                if (r_ins_en && (r_key != '0) && !scan_res.hit) begin
                    if (scan_res.free_ok) begin
                        key_cmd.set = fire;
                        wr_idx      = free_idx;
                        flag_we     = fire;
                        flag_widx   = free_idx;
                        flag_wdata  = '0;
                    end else begin
                        res_dropped = 1'b1;
                    end
                end
            end
            MODE_REMOVE: begin
                res_found   = scan_res.hit;
                key_cmd.clr = fire && scan_res.hit;
            end
            MODE_QUERY: begin
                res_found = scan_res.hit;
            end
            MODE_RAISE: begin
                res_found = scan_res.hit;
                if (scan_res.hit && core_ok) begin
                    flag_we     = fire;
                    flag_wdata  = r_flag_rd | core_mask;
                    res_pending = 1'b1;
                end
            end
            MODE_TAKE: begin
                res_found = scan_res.hit;
                if (scan_res.hit && core_ok) begin
                    flag_we    = fire;
                    flag_wdata = r_flag_rd & ~core_mask;
                end
            end
            default: begin
                res_found = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_ins_en <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_core <= i_core;
        end
    end

    // flag memory: one write port, one registered read port on the hit slot
    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            r_flag_mem[flag_widx] <= flag_wdata;
        end
        r_flag_rd <= r_flag_mem[hit_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_found   <= res_found;
            r_pending <= res_pending;
            r_dropped <= res_dropped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_pending   = r_pending;
    assign o_dropped   = r_dropped;

endmodule

/* hdl/kpft_checker.sv */
// port-level checks for the keyed pending flag table and their bind
`timescale 1ns / 1ps
module kpft_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_found,
    input logic o_pending,
    input logic o_dropped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_found) && $stable(o_pending) && $stable(o_dropped))
        else $error("stalled result changed");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped |-> !o_found && !o_pending)
        else $error("dropped insert reported a present key");

    a_pend_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pending |-> o_found)
        else $error("pending flag without a key");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("transaction accepted on consecutive cycles");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind keyed_pending_flag_table kpft_checker u_kpft_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_found    (o_found),
    .o_pending  (o_pending),
    .o_dropped  (o_dropped)
);

/* dv/keyed_pending_flag_table_test.sv */
// self-checking testbench for the keyed pending flag table
`timescale 1ns / 1ps
module keyed_pending_flag_table_test;
    import kpft_pkg::*;

    localparam int POOL_N = 80;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [KEY_W-1:0] KEY_TOP  = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_ZERO = '0;
    localparam logic [MODE_W-1:0] MODE_BAD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_BAD7 = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [CORE_W-1:0] core;
    } t_request;

    typedef struct packed {
        logic found;
        logic pending;
        logic dropped;
    } t_verdict;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_wdata = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [MODE_W-1:0] i_mode      = '0;
    logic [KEY_W-1:0]  i_key       = '0;
    logic [CORE_W-1:0] i_core      = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_found;
    logic              o_pending;
    logic              o_dropped;

    keyed_pending_flag_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .i_core      (i_core),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found     (o_found),
        .o_pending   (o_pending),
        .o_dropped   (o_dropped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the table
    logic                       insert_on = 1'b1;
    logic                       slot_used [KPFT_TABLE_DEPTH];
    logic [KEY_W-1:0]           slot_key  [KPFT_TABLE_DEPTH];
    logic [KPFT_CORE_COUNT-1:0] pend_bits [KPFT_TABLE_DEPTH];

    t_request         request_q [$];
    t_verdict         predicted_q [$];
    logic [KEY_W-1:0] key_pool [POOL_N];

    int  pushed_cnt = 0;
    int  taken_cnt  = 0;
    int  sent_cnt   = 0;
    int  err_cnt    = 0;
    int  in_gap     = 0;
    int  out_hold   = 0;
    int  calm_left  = 0;
    logic calm      = 1'b0;

    function automatic t_verdict predict_access(t_request r);
        t_verdict res;
        int       hit_idx  = -1;
        int       free_idx = -1;
        logic     core_ok;
        res = '0;
        core_ok = (r.core < KPFT_CORE_COUNT);
        if (r.key != '0) begin
            for (int i = 0; i < KPFT_TABLE_DEPTH; i++) begin
                if (hit_idx < 0 && slot_used[i] && slot_key[i] == r.key)
                    hit_idx = i;
            end
        end
        if (r.mode <= MODE_TAKE)
            res.found = (hit_idx >= 0);
        case (r.mode)
            MODE_INSERT: begin
                if (insert_on && r.key != '0 && hit_idx < 0) begin
                    for (int i = 0; i < KPFT_TABLE_DEPTH; i++) begin
                        if (free_idx < 0 && !slot_used[i])
                            free_idx = i;
                    end
                    if (free_idx < 0) begin
                        res.dropped = 1'b1;
                    end else begin
                        slot_used[free_idx] = 1'b1;
                        slot_key[free_idx]  = r.key;
                        pend_bits[free_idx] = '0;
                    end
                end
            end
            MODE_REMOVE: begin
                if (hit_idx >= 0)
                    slot_used[hit_idx] = 1'b0;
            end
            MODE_RAISE: begin
                if (hit_idx >= 0 && core_ok) begin
                    pend_bits[hit_idx][r.core] = 1'b1;
                    res.pending = 1'b1;
                end
            end
            MODE_TAKE: begin
                if (hit_idx >= 0 && core_ok)
                    pend_bits[hit_idx][r.core] = 1'b0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 80)
            return $urandom_range(1, 4);
        if (r < 96)
            return $urandom_range(5, 30);
        return $urandom_range(40, 150);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 14)
            return {$urandom, $urandom};
        return key_pool[$urandom_range(0, POOL_N-1)];
    endfunction

    function automatic t_request random_access();
        t_request r;
        int       m = $urandom_range(0, 99);
        if (m < 28)
            r.mode = MODE_INSERT;
        else if (m < 43)
            r.mode = MODE_REMOVE;
        else if (m < 58)
            r.mode = MODE_QUERY;
        else if (m < 78)
            r.mode = MODE_RAISE;
        else if (m < 95)
            r.mode = MODE_TAKE;
        else
            r.mode = MODE_W'($urandom_range(5, 7));
        r.key  = pick_key();
        r.core = CORE_W'($urandom_range(0, KPFT_CORE_COUNT-1));
        return r;
    endfunction

    task automatic queue_access(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                logic [CORE_W-1:0] core);
        request_q.push_back({mode, key, core});
        pushed_cnt++;
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) begin
            request_q.push_back(random_access());
            pushed_cnt++;
        end
    endtask

    task automatic drain();
        while (!(taken_cnt == pushed_cnt && predicted_q.size() == 0))
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_insert_enable(logic value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        insert_on = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic flag_mismatch(string what, t_verdict want, t_verdict got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch (%s): expected found=%0b pending=%0b dropped=%0b, got %0b %0b %0b",
                     what, want.found, want.pending, want.dropped,
                     got.found, got.pending, got.dropped);
    endtask

    // stretches with and without idling
    always @(negedge i_clk) begin
        if (calm_left == 0) begin
            calm      <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(200, 2000);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && taken_cnt != sent_cnt)) begin
            if (in_gap > 0) begin
                i_in_valid <= 1'b0;
                in_gap     <= in_gap - 1;
            end else if (request_q.size() > 0) begin
                {i_mode, i_key, i_core} <= request_q.pop_front();
                i_in_valid <= 1'b1;
                sent_cnt   <= sent_cnt + 1;
                in_gap     <= calm ? 0 : pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold    <= out_hold - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (!calm && $urandom_range(0, 7) == 0)
                out_hold <= pick_gap();
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_found, o_pending, o_dropped};
                if (predicted_q.size() == 0) begin
                    flag_mismatch("unexpected transaction", '0, got);
                end else begin
                    want = predicted_q.pop_front();
                    if (got !== want)
                        flag_mismatch("result", want, got);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predicted_q.push_back(predict_access({i_mode, i_key, i_core}));
                taken_cnt++;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < KPFT_TABLE_DEPTH; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            pend_bits[i] = '0;
        end
        for (int i = 0; i < POOL_N; i++)
            key_pool[i] = {$urandom, 24'($urandom), 8'(i + 1)};
        key_pool[0] = KEY_ONES;
        key_pool[1] = 64'd1;
        key_pool[2] = KEY_TOP;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_insert_enable(1'b1);
        queue_access(MODE_QUERY,  KEY_ZERO, 6'd0);
        queue_access(MODE_INSERT, KEY_ZERO, 6'd0);
        queue_access(MODE_RAISE,  KEY_ZERO, 6'd5);
        queue_access(MODE_INSERT, KEY_ONES, 6'd63);
        queue_access(MODE_INSERT, KEY_ONES, 6'd0);
        queue_access(MODE_QUERY,  KEY_ONES, 6'd63);
        queue_access(MODE_RAISE,  KEY_ONES, 6'd63);
        queue_access(MODE_RAISE,  KEY_ONES, 6'd0);
        queue_access(MODE_QUERY,  KEY_ONES, 6'd63);
        queue_access(MODE_TAKE,   KEY_ONES, 6'd63);
        queue_access(MODE_RAISE,  KEY_ONES, 6'd63);
        queue_access(MODE_REMOVE, KEY_ONES, 6'd0);
        queue_access(MODE_REMOVE, KEY_ONES, 6'd0);
        queue_access(MODE_RAISE,  KEY_ONES, 6'd1);
        queue_access(MODE_TAKE,   KEY_ONES, 6'd1);
        queue_access(MODE_INSERT, 64'd1,    6'd42);
        queue_access(MODE_RAISE,  64'd1,    6'd42);
        queue_access(MODE_BAD5,   64'd1,    6'd42);
        queue_access(MODE_BAD6,   64'd1,    6'd0);
        queue_access(MODE_BAD7,   64'd1,    6'd63);
        queue_access(MODE_INSERT, KEY_ONES, 6'd7);
        queue_access(MODE_TAKE,   64'd1,    6'd42);

        write_insert_enable(1'b0);
        queue_access(MODE_INSERT, KEY_TOP, 6'd3);
        queue_access(MODE_INSERT, 64'd1,   6'd3);
        queue_access(MODE_QUERY,  KEY_TOP, 6'd3);
        queue_random(80);

        // fill the table past its capacity
        write_insert_enable(1'b1);
        for (int i = 0; i < 70; i++)
            queue_access(MODE_INSERT, key_pool[i], CORE_W'($urandom_range(0, 63)));
        queue_random(40);

        write_insert_enable(1'b1);
        queue_random(200);

        write_insert_enable(1'b0);
        queue_random(80);

        write_insert_enable(1'b1);
        queue_random(80);

        drain();
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
